// ===== design/cc_pkg.sv =====
package cc_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned NUM_WORDS   = 16;
  localparam int unsigned KEY_WORDS   = 8;
  localparam int unsigned NONCE_WORDS = 3;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned POS_W       = 6;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;

  localparam int unsigned DEF_DOUBLE_ROUNDS = 10;
  localparam int unsigned DEF_QUEUE_DEPTH   = 4;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // register map
  localparam cfg_idx_t REG_KEY_01   = 3'd0;
  localparam cfg_idx_t REG_KEY_23   = 3'd1;
  localparam cfg_idx_t REG_KEY_45   = 3'd2;
  localparam cfg_idx_t REG_KEY_67   = 3'd3;
  localparam cfg_idx_t REG_NONCE_01 = 3'd4;
  localparam cfg_idx_t REG_NONCE_2  = 3'd5;
  localparam cfg_idx_t REG_INIT_CTR = 3'd6;

  localparam word_t INIT_CTR_RESET = 32'd1;
  localparam logic [POS_W-1:0] POS_LAST = 6'd63;

  localparam word_t SIGMA [4] = '{32'h61707865, 32'h3320646E, 32'h79622D32, 32'h6B206574};

  // one queued byte, tagged by the front with its place in the block
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              first;
    logic [POS_W-1:0]  pos;
  } item_t;

  // restart request from a register write; init_ctr is the counter to reload
  typedef struct packed {
    logic  valid;
    word_t init_ctr;
  } restart_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } quad_t;

  function automatic word_t rotl(word_t v, int unsigned s);
    return (v << s) | (v >> (WORD_W - s));
  endfunction

  // half of a quarter round: rotations 16/12 first, 8/7 second
  function automatic quad_t half_qr(quad_t q, logic second);
    quad_t r;
    r   = q;
    r.a = r.a + r.b;
    r.d = second ? rotl(r.d ^ r.a, 8) : rotl(r.d ^ r.a, 16);
    r.c = r.c + r.d;
    r.b = second ? rotl(r.b ^ r.c, 7) : rotl(r.b ^ r.c, 12);
    return r;
  endfunction

endpackage

// ===== design/cc_front.sv =====
module cc_front #(
  parameter int unsigned QUEUE_DEPTH = cc_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [cc_pkg::BYTE_W-1:0] in_byte_i,
  input  logic                      last_of_message_i,
  input  cc_pkg::restart_t          restart_i,
  input  logic                      deq_i,
  output logic                      head_valid_o,
  output cc_pkg::item_t             head_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  cc_pkg::item_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]         wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [cc_pkg::POS_W-1:0] pos_q, pos_d;
  cc_pkg::item_t            item;
  logic                     enq;

  assign full         = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign enq          = push && !full;
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // classify: position in block, block start flag
  always_comb begin
    item.data  = in_byte_i;
    item.last  = last_of_message_i;
    item.first = (pos_q == '0);
    item.pos   = pos_q;
  end

  always_comb begin
    pos_d = pos_q;
    if (restart_i.valid) begin
      pos_d = '0;
    end else if (enq) begin
      pos_d = last_of_message_i ? '0 : pos_q + 1'b1;
    end
  end

  always_comb begin
    unique case ({enq, deq_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

  // pointers wrap at the last entry, so any depth of two or more works
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      pos_q    <= '0;
    end else begin
      if (enq)   wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      if (deq_i) rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
      pos_q <= pos_d;
    end
  end

endmodule

// ===== design/cc_core.sv =====
module cc_core #(
  parameter int unsigned DOUBLE_ROUNDS = cc_pkg::DEF_DOUBLE_ROUNDS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  cc_pkg::word_t ctr_i,
  input  cc_pkg::word_t key_i   [cc_pkg::KEY_WORDS],
  input  cc_pkg::word_t nonce_i [cc_pkg::NONCE_WORDS],
  output logic          done_o,
  output cc_pkg::word_t ks_o    [cc_pkg::NUM_WORDS]
);

  localparam int unsigned RND_W = $clog2(DOUBLE_ROUNDS);
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(DOUBLE_ROUNDS - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [1:0]       phase_q;   // [1]: diagonal round, [0]: second half
  logic [RND_W-1:0] rnd_q;

  cc_pkg::word_t init  [cc_pkg::NUM_WORDS];
  cc_pkg::word_t w_q   [cc_pkg::NUM_WORDS];
  cc_pkg::word_t w_stp [cc_pkg::NUM_WORDS];
  cc_pkg::word_t ks_q  [cc_pkg::NUM_WORDS];

  always_comb begin
    for (int unsigned i = 0; i < 4; i++) init[i] = cc_pkg::SIGMA[i];
    for (int unsigned i = 0; i < cc_pkg::KEY_WORDS; i++) init[4 + i] = key_i[i];
    init[12] = ctr_i;
    for (int unsigned i = 0; i < cc_pkg::NONCE_WORDS; i++) init[13 + i] = nonce_i[i];
  end

  // four quarter rounds side by side; diagonal lanes rotate the b/c/d rows
  always_comb begin
    cc_pkg::quad_t q;
    logic [3:0]    ia, ib, ic, id;
    logic [1:0]    dg;
    dg    = {1'b0, phase_q[1]};
    w_stp = w_q;
    for (int unsigned i = 0; i < 4; i++) begin
      ia  = 4'(i);
      ib  = {2'b01, 2'(2'(i) + dg)};
      ic  = {2'b10, 2'(2'(i) + {dg, 1'b0})};
      id  = {2'b11, 2'(2'(i) + dg + {dg, 1'b0})};
      q   = cc_pkg::half_qr({w_q[ia], w_q[ib], w_q[ic], w_q[id]}, phase_q[0]);
      w_stp[ia] = q.a;
      w_stp[ib] = q.b;
      w_stp[ic] = q.c;
      w_stp[id] = q.d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start_i) state_d = ST_ROUND;
      ST_ROUND: if (phase_q == 2'd3 && rnd_q == RND_LAST) state_d = ST_FINAL;
      ST_FINAL: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= '0;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_ROUND) begin
        phase_q <= phase_q + 1'b1;
        if (phase_q == 2'd3) rnd_q <= rnd_q + 1'b1;
      end else begin
        phase_q <= '0;
        rnd_q   <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      w_q <= init;
    end else if (state_q == ST_ROUND) begin
      w_q <= w_stp;
    end
    if (state_q == ST_FINAL) begin
      for (int unsigned i = 0; i < cc_pkg::NUM_WORDS; i++) ks_q[i] <= w_q[i] + init[i];
    end
  end

  assign done_o = (state_q == ST_FINAL);
  assign ks_o   = ks_q;

endmodule

// ===== design/cc_back.sv =====
module cc_back #(
  parameter int unsigned DOUBLE_ROUNDS = cc_pkg::DEF_DOUBLE_ROUNDS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      head_valid_i,
  input  cc_pkg::item_t             head_i,
  output logic                      deq_o,
  input  cc_pkg::restart_t          restart_i,
  input  cc_pkg::word_t             key_i   [cc_pkg::KEY_WORDS],
  input  cc_pkg::word_t             nonce_i [cc_pkg::NONCE_WORDS],
  input  logic                      pop,
  output logic                      empty,
  output logic [cc_pkg::BYTE_W-1:0] out_byte_o,
  output logic                      out_last_o
);

  localparam logic ST_RUN = 1'b0;
  localparam logic ST_GEN = 1'b1;

  logic                      state_q;
  logic                      fresh_q;    // keystream belongs to the head's block
  cc_pkg::word_t             ctr_q;
  logic                      out_valid_q;
  logic [cc_pkg::BYTE_W-1:0] out_byte_q;
  logic                      out_last_q;

  logic                      slot_free, core_start, core_done, consume;
  cc_pkg::word_t             ks [cc_pkg::NUM_WORDS];
  cc_pkg::word_t             ks_word;
  logic [cc_pkg::BYTE_W-1:0] ks_byte;

  cc_core #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(core_start),
    .ctr_i  (ctr_q),
    .key_i  (key_i),
    .nonce_i(nonce_i),
    .done_o (core_done),
    .ks_o   (ks)
  );

  assign slot_free  = !out_valid_q || pop;
  assign core_start = (state_q == ST_RUN) && head_valid_i && head_i.first && !fresh_q;
  assign consume    = (state_q == ST_RUN) && head_valid_i && (!head_i.first || fresh_q) &&
                      slot_free;
  assign deq_o      = consume;

  assign ks_word = ks[head_i.pos[cc_pkg::POS_W-1:2]];
  assign ks_byte = ks_word[{head_i.pos[1:0], 3'b000} +: cc_pkg::BYTE_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      fresh_q     <= 1'b0;
      ctr_q       <= cc_pkg::INIT_CTR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (consume) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
      if (restart_i.valid) begin
        ctr_q   <= restart_i.init_ctr;
        fresh_q <= 1'b0;
        state_q <= ST_RUN;
      end else begin
        unique case (state_q)
          ST_RUN: begin
            if (core_start) state_q <= ST_GEN;
          end
          ST_GEN: begin
            if (core_done) begin
              state_q <= ST_RUN;
              fresh_q <= 1'b1;
            end
          end
          default: state_q <= ST_RUN;
        endcase
        if (consume) begin
          fresh_q <= 1'b0;
          priority if (head_i.last) begin
            ctr_q <= restart_i.init_ctr;
          end else if (head_i.pos == cc_pkg::POS_LAST) begin
            ctr_q <= ctr_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume) begin
      out_byte_q <= head_i.data ^ ks_byte;
      out_last_q <= head_i.last;
    end
  end

  assign empty      = !out_valid_q;
  assign out_byte_o = out_byte_q;
  assign out_last_o = out_last_q;

endmodule

// ===== design/chacha20_keystream_xor.sv =====
// ChaCha20 (RFC 8439) keystream XOR, one byte per transfer in each direction;
// encryption and decryption are the same operation. Key, nonce and the
// starting block counter are written through the cfg port while the block is
// idle; any write to a defined register (index 0..6) restarts the message at
// byte 0 of a fresh block with the block counter reloaded, and index 7 is
// ignored. Bytes enter a QUEUE_DEPTH-entry queue, where each is tagged with
// its place in the 64-byte block. Within a block one byte leaves per cycle
// while results are popped. The first byte of each block waits for the block
// function, which starts only once that byte is at the queue head, so it never
// overlaps the previous block: four quarter-round lanes side by side do half a
// round per cycle through DOUBLE_ROUNDS double rounds, then a final step adds
// the input state. A mid-block byte passes through the queue and the output
// register. A byte with last_of_message set ends the message: the next byte
// starts a new block at the configured initial counter. Otherwise the counter
// advances by one modulo 2^32 after each block.
module chacha20_keystream_xor #(
  parameter int unsigned DOUBLE_ROUNDS = cc_pkg::DEF_DOUBLE_ROUNDS,
  parameter int unsigned QUEUE_DEPTH   = cc_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input queue side
  input  logic                          push,
  output logic                          full,
  input  logic [cc_pkg::BYTE_W-1:0]     in_byte_i,
  input  logic                          last_of_message_i,
  // result queue side
  output logic                          empty,
  input  logic                          pop,
  output logic [cc_pkg::BYTE_W-1:0]     out_byte_o,
  output logic                          out_last_o,
  // register writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  cc_pkg::word_t    key_q   [cc_pkg::KEY_WORDS];
  cc_pkg::word_t    nonce_q [cc_pkg::NONCE_WORDS];
  cc_pkg::word_t    init_ctr_q;

  cc_pkg::word_t    lo, hi;
  logic             cfg_wr;
  cc_pkg::restart_t restart;
  logic             deq, head_valid;
  cc_pkg::item_t    head;

  // writes are always taken
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign lo          = cfg_data_i[31:0];
  assign hi          = cfg_data_i[63:32];

  // restart takes effect on the write's transfer edge, in front and back alike;
  // the counter to reload follows a same-edge write of the initial counter
  assign restart.valid    = cfg_wr && (cfg_index_i <= cc_pkg::REG_INIT_CTR);
  assign restart.init_ctr = (cfg_wr && cfg_index_i == cc_pkg::REG_INIT_CTR) ? lo : init_ctr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < cc_pkg::KEY_WORDS; i++) key_q[i] <= '0;
      for (int unsigned i = 0; i < cc_pkg::NONCE_WORDS; i++) nonce_q[i] <= '0;
      init_ctr_q <= cc_pkg::INIT_CTR_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        cc_pkg::REG_KEY_01: begin
          key_q[0] <= lo;
          key_q[1] <= hi;
        end
        cc_pkg::REG_KEY_23: begin
          key_q[2] <= lo;
          key_q[3] <= hi;
        end
        cc_pkg::REG_KEY_45: begin
          key_q[4] <= lo;
          key_q[5] <= hi;
        end
        cc_pkg::REG_KEY_67: begin
          key_q[6] <= lo;
          key_q[7] <= hi;
        end
        cc_pkg::REG_NONCE_01: begin
          nonce_q[0] <= lo;
          nonce_q[1] <= hi;
        end
        cc_pkg::REG_NONCE_2:  nonce_q[2] <= lo;
        cc_pkg::REG_INIT_CTR: init_ctr_q <= lo;
        default: ;  // undefined index: no effect
      endcase
    end
  end

  cc_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .in_byte_i        (in_byte_i),
    .last_of_message_i(last_of_message_i),
    .restart_i        (restart),
    .deq_i            (deq),
    .head_valid_o     (head_valid),
    .head_o           (head)
  );

  cc_back #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .deq_o       (deq),
    .restart_i   (restart),
    .key_i       (key_q),
    .nonce_i     (nonce_q),
    .pop         (pop),
    .empty       (empty),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule

// ===== design/cc_port_checker.sv =====
module cc_port_checker #(
  parameter int unsigned QUEUE_DEPTH = cc_pkg::DEF_QUEUE_DEPTH
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      push,
  input logic                      full,
  input logic                      empty,
  input logic                      pop,
  input logic [cc_pkg::BYTE_W-1:0] out_byte_o,
  input logic                      out_last_o
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 2);

  // bytes taken in but not yet delivered
  logic [CNT_W-1:0] inflight_q;
  logic             in_xfer, out_xfer;

  assign in_xfer  = push && !full;
  assign out_xfer = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + CNT_W'(in_xfer) - CNT_W'(out_xfer);
    end
  end

  a_empty_in_reset: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result visible during reset");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(out_last_o)))
    else $error("stalled result changed or vanished");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inflight_q == '0) |-> empty)
    else $error("result without a pending input byte");

  a_full_needs_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> (inflight_q != '0))
    else $error("full with nothing in flight");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CNT_W'(QUEUE_DEPTH + 1))
    else $error("more bytes in flight than storage");

endmodule

bind chacha20_keystream_xor cc_port_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_port_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .push      (push),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .out_byte_o(out_byte_o),
  .out_last_o(out_last_o)
);
